// File: hdl/lbc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbc_pkg
// Types and constants shared by the buffer cache modules.
// ----------------------------------------------------------------------------
package lbc_pkg;

   localparam int NUM_BUFFERS = 32;
   localparam int IDX_W = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
   localparam logic [7:0] COUNT_MAX = 8'hFF;

   localparam logic [2:0] OP_ACQUIRE = 3'd0;
   localparam logic [2:0] OP_RELEASE = 3'd1;
   localparam logic [2:0] OP_PIN = 3'd2;
   localparam logic [2:0] OP_UNPIN = 3'd3;
   localparam logic [2:0] OP_FILL = 3'd4;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_NO_FREE = 2'd1;
   localparam logic [1:0] ST_COUNT_ERR = 2'd2;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_READ,
      S_EXEC,
      S_MTF,
      S_OUT
   } state_type;

   typedef struct packed {
      logic [7:0] device;
      logic [23:0] block;
      logic valid;
      logic [7:0] count;
      logic [IDX_W-1:0] rank;
   } entry_type;

   typedef struct packed {
      logic [2:0] req_type;
      logic [7:0] device;
      logic [23:0] block_number;
      logic [4:0] buffer_index;
   } req_type_type;

   typedef struct packed {
      logic [1:0] status;
      logic hit;
      logic needs_fill;
      logic [4:0] result_buffer;
      logic [7:0] ref_count;
      logic [4:0] recency_position;
   } rsp_type;

   typedef struct packed {
      logic wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type wr_data;
      logic rd_en;
      logic [IDX_W-1:0] rd_addr;
   } mem_cmd_type;

endpackage
`default_nettype wire

// File: hdl/lbc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbc_ram
// Simple dual-port synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module lbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input wire logic [WIDTH-1:0] wr_data,
   input wire logic rd_en,
   input wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// File: hdl/lbc_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lbc_engine
// Sequencer: clearing pass, tag scan, read-modify-write and recency update.
// ----------------------------------------------------------------------------
module lbc_engine (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire lbc_pkg::req_type_type req,
   output logic req_ready,
   output logic res_valid,
   output lbc_pkg::rsp_type res,
   input wire logic res_ready,
   output lbc_pkg::mem_cmd_type mem_cmd,
   input wire lbc_pkg::entry_type rd_data
);

   localparam logic [lbc_pkg::IDX_W-1:0] LAST = lbc_pkg::IDX_W'(lbc_pkg::NUM_BUFFERS - 1);

   lbc_pkg::state_type state_ff, state_in;
   lbc_pkg::req_type_type req_ff, req_in;
   lbc_pkg::rsp_type res_ff, res_in;
   logic [lbc_pkg::IDX_W-1:0] cnt_ff, cnt_in;
   logic last_ff, last_in;
   logic rdv_ff, rdv_in;
   logic [lbc_pkg::IDX_W-1:0] rda_ff, rda_in;
   logic m_found_ff, m_found_in;
   logic [lbc_pkg::IDX_W-1:0] m_idx_ff, m_idx_in;
   lbc_pkg::entry_type m_word_ff, m_word_in;
   logic f_found_ff, f_found_in;
   logic [lbc_pkg::IDX_W-1:0] f_idx_ff, f_idx_in;
   logic [lbc_pkg::IDX_W-1:0] f_rank_ff, f_rank_in;
   logic [lbc_pkg::IDX_W-1:0] mtf_rank_ff, mtf_rank_in;

   logic [lbc_pkg::IDX_W-1:0] addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lbc_pkg::S_INIT;
         rdv_ff <= 1'b0;
         cnt_ff <= '0;
         last_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rdv_ff <= rdv_in;
         cnt_ff <= cnt_in;
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      res_ff <= res_in;
      rda_ff <= rda_in;
      m_found_ff <= m_found_in;
      m_idx_ff <= m_idx_in;
      m_word_ff <= m_word_in;
      f_found_ff <= f_found_in;
      f_idx_ff <= f_idx_in;
      f_rank_ff <= f_rank_in;
      mtf_rank_ff <= mtf_rank_in;
   end

   assign addr = lbc_pkg::IDX_W'(req_ff.buffer_index);

   always_comb begin
      lbc_pkg::entry_type w;
      state_in = state_ff;
      req_in = req_ff;
      res_in = res_ff;
      cnt_in = cnt_ff;
      last_in = last_ff;
      rdv_in = 1'b0;
      rda_in = rda_ff;
      m_found_in = m_found_ff;
      m_idx_in = m_idx_ff;
      m_word_in = m_word_ff;
      f_found_in = f_found_ff;
      f_idx_in = f_idx_ff;
      f_rank_in = f_rank_ff;
      mtf_rank_in = mtf_rank_ff;
      mem_cmd = '0;
      req_ready = 1'b0;
      res_valid = 1'b0;
      w = rd_data;

      case (state_ff)
         lbc_pkg::S_INIT: begin
            mem_cmd.wr_en = 1'b1;
            mem_cmd.wr_addr = cnt_ff;
            mem_cmd.wr_data = '0;
            mem_cmd.wr_data.rank = LAST - cnt_ff;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST) begin
               cnt_in = '0;
               state_in = lbc_pkg::S_IDLE;
            end
         end
         lbc_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in = req;
               res_in = '0;
               cnt_in = '0;
               last_in = 1'b0;
               m_found_in = 1'b0;
               f_found_in = 1'b0;
               if (req.req_type == lbc_pkg::OP_ACQUIRE) begin
                  state_in = lbc_pkg::S_SCAN;
               end else if (req.req_type > lbc_pkg::OP_FILL) begin
                  state_in = lbc_pkg::S_OUT;
               end else if (int'(req.buffer_index) >= lbc_pkg::NUM_BUFFERS) begin
                  res_in.result_buffer = req.buffer_index;
                  state_in = lbc_pkg::S_OUT;
               end else begin
                  state_in = lbc_pkg::S_READ;
               end
            end
         end
         lbc_pkg::S_SCAN, lbc_pkg::S_MTF: begin
            if (!last_ff) begin
               mem_cmd.rd_en = 1'b1;
               mem_cmd.rd_addr = cnt_ff;
               rdv_in = 1'b1;
               rda_in = cnt_ff;
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == LAST) begin
                  last_in = 1'b1;
               end
            end
            if (rdv_ff) begin
               if (state_ff == lbc_pkg::S_SCAN) begin
                  if (rd_data.device == req_ff.device && rd_data.block == req_ff.block_number
                      && (!m_found_ff || rd_data.rank < m_word_ff.rank)) begin
                     m_found_in = 1'b1;
                     m_idx_in = rda_ff;
                     m_word_in = rd_data;
                  end
                  if (rd_data.count == 8'd0 && (!f_found_ff || rd_data.rank > f_rank_ff)) begin
                     f_found_in = 1'b1;
                     f_idx_in = rda_ff;
                     f_rank_in = rd_data.rank;
                  end
               end else if (rda_ff != addr && rd_data.rank < mtf_rank_ff) begin
                  w.rank = rd_data.rank + 1'b1;
                  mem_cmd.wr_en = 1'b1;
                  mem_cmd.wr_addr = rda_ff;
                  mem_cmd.wr_data = w;
               end
               if (rda_ff == LAST) begin
                  state_in = (state_ff == lbc_pkg::S_SCAN) ? lbc_pkg::S_DECIDE : lbc_pkg::S_OUT;
               end
            end
         end
         lbc_pkg::S_DECIDE: begin
            state_in = lbc_pkg::S_OUT;
            if (m_found_ff) begin
               w = m_word_ff;
               res_in.hit = 1'b1;
               if (m_word_ff.count == lbc_pkg::COUNT_MAX) begin
                  res_in.status = lbc_pkg::ST_COUNT_ERR;
               end else begin
                  w.count = m_word_ff.count + 1'b1;
                  mem_cmd.wr_en = 1'b1;
                  mem_cmd.wr_addr = m_idx_ff;
                  mem_cmd.wr_data = w;
               end
               res_in.needs_fill = !w.valid;
               res_in.result_buffer = 5'(m_idx_ff);
               res_in.ref_count = w.count;
               res_in.recency_position = 5'(w.rank);
            end else if (f_found_ff) begin
               w.device = req_ff.device;
               w.block = req_ff.block_number;
               w.valid = 1'b0;
               w.count = 8'd1;
               w.rank = f_rank_ff;
               mem_cmd.wr_en = 1'b1;
               mem_cmd.wr_addr = f_idx_ff;
               mem_cmd.wr_data = w;
               res_in.needs_fill = 1'b1;
               res_in.result_buffer = 5'(f_idx_ff);
               res_in.ref_count = 8'd1;
               res_in.recency_position = 5'(f_rank_ff);
            end else begin
               res_in.status = lbc_pkg::ST_NO_FREE;
            end
         end
         lbc_pkg::S_READ: begin
            mem_cmd.rd_en = 1'b1;
            mem_cmd.rd_addr = addr;
            state_in = lbc_pkg::S_EXEC;
         end
         lbc_pkg::S_EXEC: begin
            state_in = lbc_pkg::S_OUT;
            mem_cmd.wr_addr = addr;
            case (req_ff.req_type)
               lbc_pkg::OP_RELEASE, lbc_pkg::OP_UNPIN: begin
                  if (rd_data.count == 8'd0) begin
                     res_in.status = lbc_pkg::ST_COUNT_ERR;
                  end else begin
                     w.count = rd_data.count - 1'b1;
                     mem_cmd.wr_en = 1'b1;
                     if (req_ff.req_type == lbc_pkg::OP_RELEASE && w.count == 8'd0) begin
                        w.rank = '0;
                        mtf_rank_in = rd_data.rank;
                        cnt_in = '0;
                        last_in = 1'b0;
                        state_in = lbc_pkg::S_MTF;
                     end
                  end
               end
               lbc_pkg::OP_PIN: begin
                  if (rd_data.count == lbc_pkg::COUNT_MAX) begin
                     res_in.status = lbc_pkg::ST_COUNT_ERR;
                  end else begin
                     w.count = rd_data.count + 1'b1;
                     mem_cmd.wr_en = 1'b1;
                  end
               end
               default: begin
                  w.valid = 1'b1;
                  mem_cmd.wr_en = 1'b1;
               end
            endcase
            mem_cmd.wr_data = w;
            res_in.needs_fill = !w.valid;
            res_in.result_buffer = req_ff.buffer_index;
            res_in.ref_count = w.count;
            res_in.recency_position = 5'(w.rank);
         end
         lbc_pkg::S_OUT: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = lbc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = lbc_pkg::S_IDLE;
         end
      endcase
   end

   assign res = res_ff;

endmodule
`default_nettype wire

// File: hdl/lru_block_buffer_cache.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_block_buffer_cache
// Disk-block buffer tag cache with reference counts and lru replacement.
// ----------------------------------------------------------------------------
// channel  direction  contents
// req_     in         tuser: req_type[2:0]; tdata: device, block_number, buffer_index
// rsp_     out        tuser: status[1:0]; tdata: hit, needs_fill, result_buffer,
//                     ref_count, recency_position
//
// acquire scans every tag entry, one tag memory read per cycle of the scan
// release, pin, unpin and fill done read, modify and write one entry; a release that frees
// the buffer adds a recency update pass over every entry
// after reset a clearing pass over every entry runs before req_tready rises
// one transaction in flight; the output register frees the engine once taken
// ----------------------------------------------------------------------------
module lru_block_buffer_cache (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   output logic req_tready,
   input wire logic [2:0] req_tuser,   // req_type
   input wire logic [39:0] req_tdata,  // device, block_number, buffer_index, zero pad
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   output logic [1:0] rsp_tuser,       // status
   output logic [23:0] rsp_tdata       // hit, needs_fill, result_buffer, ref_count,
                                       // recency_position, zero pad
);

   lbc_pkg::req_type_type req;
   lbc_pkg::rsp_type res;
   lbc_pkg::rsp_type rsp_ff;
   lbc_pkg::mem_cmd_type mem_cmd;
   lbc_pkg::entry_type rd_data;
   logic rsp_valid_ff, rsp_valid_in;
   logic res_valid, res_ready;

   assign req.req_type = req_tuser;
   assign req.device = req_tdata[7:0];
   assign req.block_number = req_tdata[31:8];
   assign req.buffer_index = req_tdata[36:32];

   lbc_ram #(
      .WIDTH($bits(lbc_pkg::entry_type)),
      .DEPTH(lbc_pkg::NUM_BUFFERS)
   ) u_ram (
      .clock(clock),
      .wr_en(mem_cmd.wr_en),
      .wr_addr(mem_cmd.wr_addr),
      .wr_data(mem_cmd.wr_data),
      .rd_en(mem_cmd.rd_en),
      .rd_addr(mem_cmd.rd_addr),
      .rd_data(rd_data)
   );

   lbc_engine u_engine (
      .clock(clock),
      .reset(reset),
      .req_valid(req_tvalid),
      .req(req),
      .req_ready(req_tready),
      .res_valid(res_valid),
      .res(res),
      .res_ready(res_ready),
      .mem_cmd(mem_cmd),
      .rd_data(rd_data)
   );

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = rsp_ff.status;
   assign rsp_tdata = {4'd0, rsp_ff.recency_position, rsp_ff.ref_count,
                       rsp_ff.result_buffer, rsp_ff.needs_fill, rsp_ff.hit};

endmodule
`default_nettype wire
